>>> hdl/m3i_pkg.sv
// Package for the 3x3 fixed-point matrix inverse.
// Holds the width constants, the stage payload types and the divider helper
// functions. It depends on nothing else.
`default_nettype none

package m3i_pkg;

    // Entry format and output format.
    localparam int EW       = 16;
    localparam int FRAC     = 8;
    localparam int OUT_FRAC = 16;
    localparam int NELEM    = 9;

    // Derived widths of the intermediate values.
    localparam int PW  = 2 * EW;          // product of two entries
    localparam int MW  = 2 * EW + 1;      // signed 2x2 minor
    localparam int DW  = 3 * EW + 1;      // signed determinant
    localparam int DMW = 3 * EW;          // determinant magnitude
    localparam int AMW = 2 * EW;          // cofactor magnitude
    localparam int SHN = FRAC + OUT_FRAC; // numerator left shift
    localparam int NW  = AMW + SHN + 1;   // numerator width, one spare bit
    localparam int QW  = 32;              // quotient bits, one per divider step
    localparam int HW  = NW - QW;         // numerator bits above the quotient
    localparam int SW  = DMW + QW + 1;    // width used for saturation

    // Rescaling of the determinant to Q16.16.
    localparam int DSH    = 3 * FRAC - OUT_FRAC;
    localparam int DSH_R  = (DSH > 0) ? DSH : 0;
    localparam int DSH_L  = (DSH < 0) ? -DSH : 0;
    localparam int RND_SH = (DSH_R > 0) ? DSH_R - 1 : 0;

    localparam logic [QW-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] SAT_MIN = 32'h8000_0000;

    // Cyclic neighbours of a row or column index.
    localparam int NXT1 [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};

    typedef logic [NELEM-1:0][EW-1:0] mat_t;
    typedef logic [DMW-1:0] dmag_t;
    typedef logic [AMW-1:0] amag_t;

    // Signs and magnitudes handed from the determinant stages to the divider.
    typedef struct packed {
        dmag_t                  dmag;
        logic                   dneg;
        logic                   singular;
        logic [NELEM-1:0][AMW-1:0] amag;
        logic [NELEM-1:0]       neg;
    } prep_t;

    // One divider lane: partial remainder and the numerator/quotient shift word.
    typedef struct packed {
        logic [DMW-1:0] rem;
        logic [QW-1:0]  bits;
        logic           neg;
        logic           ovf;
    } lane_t;

    // Values shared by all nine lanes of one divider stage.
    typedef struct packed {
        dmag_t          dmag;
        logic [QW-1:0]  det_q;
        logic           singular;
    } com_t;

    typedef struct packed {
        logic [NELEM-1:0][QW-1:0] r;
        logic [QW-1:0]            det;
        logic                     singular;
    } res_t;

    // Signed saturation of a sign and magnitude to 32 bits.
    function automatic logic [QW-1:0] sat32(input logic neg, input logic [SW-1:0] mag);
        logic [SW-1:0] nm;
        logic [QW-1:0] res;
        nm = ~mag + SW'(1);
        if (mag > SW'(SAT_MAX))
            res = neg ? SAT_MIN : SAT_MAX;
        else
            res = neg ? nm[QW-1:0] : mag[QW-1:0];
        return res;
    endfunction

    // Determinant magnitude moved to Q16.16, rounded half away from zero.
    function automatic logic [QW-1:0] det_q16(input logic neg, input dmag_t mag);
        logic [SW-1:0] x;
        logic [SW-1:0] t;
        x = SW'(mag);
        if (DSH_R > 0)
            t = (x + (SW'(1) << RND_SH)) >> DSH_R;
        else if (DSH_L > 0)
        begin
            if (x > ((SW'(1) << QW) >> DSH_L))
                t = SW'(1) << QW;
            else
                t = x << DSH_L;
        end
        else
            t = x;
        return sat32(neg, t);
    endfunction

    // One restoring division step: brings in the next numerator bit.
    function automatic lane_t div_step(input lane_t l, input dmag_t d);
        logic [DMW:0] sr;
        logic [DMW:0] diff;
        logic         ge;
        lane_t        o;
        sr     = {l.rem, l.bits[QW-1]};
        diff   = sr - {1'b0, d};
        ge     = (sr >= {1'b0, d});
        o      = l;
        o.rem  = ge ? diff[DMW-1:0] : sr[DMW-1:0];
        o.bits = {l.bits[QW-2:0], ge};
        return o;
    endfunction

    // Rounding to nearest, ties away from zero, then saturation.
    function automatic logic [QW-1:0] lane_result(input lane_t l, input dmag_t d);
        logic          up;
        logic [QW:0]   q;
        logic [QW-1:0] res;
        up = ({l.rem, 1'b0} >= {1'b0, d});
        q  = {1'b0, l.bits} + {{QW{1'b0}}, up};
        if (l.ovf)
            res = l.neg ? SAT_MIN : SAT_MAX;
        else
            res = sat32(l.neg, SW'(q));
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/m3i_if.sv
// Handshake interfaces for the matrix words and the result words.
// Depends on m3i_pkg for the field widths.
`default_nettype none

interface m3i_in_if import m3i_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [EW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

interface m3i_out_if import m3i_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [QW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [QW-1:0] det_value;
    logic                 singular;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    det_value, singular, input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    det_value, singular, output ready);
endinterface

`default_nettype wire

>>> hdl/matrix3_inverse.sv
// Inverse of a 3x3 signed Q8.8 matrix, one matrix word per cycle while mat.ready is high.
// Depends on m3i_pkg, m3i_if, m3i_det, m3i_div and m3i_skid.
//
// The mat channel takes one word of nine entries in row order; the res
// channel returns the nine inverse entries and the determinant in signed
// Q16.16, saturated, with a singular flag. A singular matrix gives zero
// entries, a zero determinant and the flag set.
// Throughput is one matrix per cycle while mat.ready is high: five stages
// form the cofactors and the determinant, one stage sets up the division, and
// the 32-step restoring divider, one quotient bit per stage for nine lanes,
// sets the depth. When the receiver stalls, the output register holds its
// word and one more word goes to a skid stage; only then does mat.ready fall
// and the whole pipeline hold, so nothing is lost or repeated.
// Reset clears all valid bits; the block accepts a word in the first cycle
// after reset.
`default_nettype none

module matrix3_inverse import m3i_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    m3i_in_if.sink      mat,
    m3i_out_if.source   res
);

    mat_t  in_mat;
    logic  en;
    logic  det_valid;
    prep_t det_prep;
    logic  div_valid;
    res_t  div_res;
    res_t  out_res;

    assign in_mat = {mat.m22, mat.m21, mat.m20, mat.m12, mat.m11, mat.m10,
                     mat.m02, mat.m01, mat.m00};

    assign mat.ready = en;

    m3i_det u_det
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mat.valid),
        .in_mat    (in_mat),
        .out_valid (det_valid),
        .out_prep  (det_prep)
    );

    m3i_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (det_valid),
        .in_prep   (det_prep),
        .out_valid (div_valid),
        .out_res   (div_res)
    );

    m3i_skid u_skid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (div_valid),
        .up_res     (div_res),
        .up_ready   (en),
        .down_valid (res.valid),
        .down_ready (res.ready),
        .down_res   (out_res)
    );

    // Result fields.
    assign res.r00       = out_res.r[0];
    assign res.r01       = out_res.r[1];
    assign res.r02       = out_res.r[2];
    assign res.r10       = out_res.r[3];
    assign res.r11       = out_res.r[4];
    assign res.r12       = out_res.r[5];
    assign res.r20       = out_res.r[6];
    assign res.r21       = out_res.r[7];
    assign res.r22       = out_res.r[8];
    assign res.det_value = out_res.det;
    assign res.singular  = out_res.singular;

    // A singular result carries only zeros.
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.singular |->
            res.r00 == 0 && res.r01 == 0 && res.r02 == 0 &&
            res.r10 == 0 && res.r11 == 0 && res.r12 == 0 &&
            res.r20 == 0 && res.r21 == 0 && res.r22 == 0 &&
            res.det_value == 0)
        else $error("singular result with non-zero fields");

    // The input is held off only while a result is waiting.
    a_hold_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !mat.ready |-> res.valid)
        else $error("input stalled with no result waiting");

endmodule

`default_nettype wire

>>> hdl/m3i_det.sv
// Cofactor and determinant stages: five register stages from entries to
// signed magnitudes ready for division. Depends on m3i_pkg.
`default_nettype none

module m3i_det import m3i_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  mat_t  in_mat,
    output logic  out_valid,
    output prep_t out_prep
);

    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg;

    logic signed [PW-1:0] a_p1_reg [NELEM];
    logic signed [PW-1:0] a_p2_reg [NELEM];
    logic signed [PW-1:0] a_p1_next [NELEM];
    logic signed [PW-1:0] a_p2_next [NELEM];
    logic [2:0][EW-1:0]   a_row_reg;

    logic signed [MW-1:0] b_cof_reg [NELEM];
    logic signed [MW-1:0] b_cof_next [NELEM];
    logic [2:0][EW-1:0]   b_row_reg;

    logic signed [DW-1:0] c_dp_reg [3];
    logic signed [DW-1:0] c_dp_next [3];
    logic signed [MW-1:0] c_cof_reg [NELEM];

    logic signed [DW-1:0] d_det_reg;
    logic signed [DW-1:0] d_det_next;
    logic signed [MW-1:0] d_cof_reg [NELEM];

    prep_t e_prep_reg;
    prep_t e_prep_next;

    // Stage A: the two products of every cyclic 2x2 minor.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a_p1_next[3*r+c] = $signed(in_mat[3*NXT1[r]+NXT1[c]])
                                 * $signed(in_mat[3*NXT2[r]+NXT2[c]]);
                a_p2_next[3*r+c] = $signed(in_mat[3*NXT2[r]+NXT1[c]])
                                 * $signed(in_mat[3*NXT1[r]+NXT2[c]]);
            end
        end
    end

    // Stage B: cofactors as differences of the products.
    always_comb
    begin
        for (int k = 0; k < NELEM; k++)
        begin
            b_cof_next[k] = {a_p1_reg[k][PW-1], a_p1_reg[k]}
                          - {a_p2_reg[k][PW-1], a_p2_reg[k]};
        end
    end

    // Stage C: first-row entries times their cofactors.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            c_dp_next[j] = $signed(b_row_reg[j]) * b_cof_reg[j];
        end
    end

    // Stage D: the determinant.
    assign d_det_next = c_dp_reg[0] + c_dp_reg[1] + c_dp_reg[2];

    // Stage E: signs and magnitudes of the determinant and the adjugate.
    // The adjugate entry in row i, column j is the cofactor of entry (j, i).
    always_comb
    begin
        logic [DW-1:0] dabs;
        logic [MW-1:0] cabs;
        logic          dneg;
        dneg = d_det_reg[DW-1];
        dabs = dneg ? (~d_det_reg + DW'(1)) : d_det_reg;
        e_prep_next.dneg     = dneg;
        e_prep_next.dmag     = dabs[DMW-1:0];
        e_prep_next.singular = (d_det_reg == '0);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cabs = d_cof_reg[3*j+i][MW-1] ? (~d_cof_reg[3*j+i] + MW'(1))
                                               : d_cof_reg[3*j+i];
                e_prep_next.amag[3*i+j] = cabs[AMW-1:0];
                e_prep_next.neg[3*i+j]  = d_cof_reg[3*j+i][MW-1] ^ dneg;
            end
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_p1_reg   <= a_p1_next;
            a_p2_reg   <= a_p2_next;
            a_row_reg  <= in_mat[2:0];
            b_cof_reg  <= b_cof_next;
            b_row_reg  <= a_row_reg;
            c_dp_reg   <= c_dp_next;
            c_cof_reg  <= b_cof_reg;
            d_det_reg  <= d_det_next;
            d_cof_reg  <= c_cof_reg;
            e_prep_reg <= e_prep_next;
        end
    end

    assign out_valid = e_v_reg;
    assign out_prep  = e_prep_reg;

endmodule

`default_nettype wire

>>> hdl/m3i_div.sv
// Pipelined divider: a set-up stage, then one restoring step per stage for
// nine lanes sharing the divisor, then rounding. Depends on m3i_pkg.
`default_nettype none

module m3i_div import m3i_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  prep_t in_prep,
    output logic  out_valid,
    output res_t  out_res
);

    logic              f_v_reg;
    lane_t [NELEM-1:0] f_lane_reg;
    lane_t [NELEM-1:0] f_lane_next;
    com_t              f_com_reg;
    com_t              f_com_next;

    logic              st_v_reg    [QW];
    lane_t [NELEM-1:0] st_lane_reg [QW];
    com_t              st_com_reg  [QW];

    // Set-up: numerator, overflow test and first partial remainder.
    always_comb
    begin
        logic [NW-1:0]  n;
        logic [DMW-1:0] hix;
        for (int k = 0; k < NELEM; k++)
        begin
            n   = {1'b0, in_prep.amag[k], {SHN{1'b0}}};
            hix = {{(DMW-HW){1'b0}}, n[NW-1:QW]};
            f_lane_next[k].rem  = hix;
            f_lane_next[k].bits = n[QW-1:0];
            f_lane_next[k].neg  = in_prep.neg[k];
            f_lane_next[k].ovf  = (hix >= in_prep.dmag);
        end
        f_com_next.dmag     = in_prep.dmag;
        f_com_next.det_q    = det_q16(in_prep.dneg, in_prep.dmag);
        f_com_next.singular = in_prep.singular;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_v_reg <= 1'b0;
        else if (en)
            f_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_lane_reg <= f_lane_next;
            f_com_reg  <= f_com_next;
        end
    end

    // Division steps, one quotient bit per stage.
    for (genvar s = 0; s < QW; s++)
    begin : g_step
        lane_t [NELEM-1:0] lane_prev;
        lane_t [NELEM-1:0] lane_next;
        com_t              com_prev;
        logic              v_prev;

        if (s == 0)
        begin : g_first
            assign lane_prev = f_lane_reg;
            assign com_prev  = f_com_reg;
            assign v_prev    = f_v_reg;
        end
        else
        begin : g_rest
            assign lane_prev = st_lane_reg[s-1];
            assign com_prev  = st_com_reg[s-1];
            assign v_prev    = st_v_reg[s-1];
        end

        always_comb
        begin
            for (int k = 0; k < NELEM; k++)
            begin
                lane_next[k] = div_step(lane_prev[k], com_prev.dmag);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_v_reg[s] <= 1'b0;
            else if (en)
                st_v_reg[s] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_lane_reg[s] <= lane_next;
                st_com_reg[s]  <= com_prev;
            end
        end
    end

    // Rounding and saturation; a singular matrix gives all zeros.
    always_comb
    begin
        for (int k = 0; k < NELEM; k++)
        begin
            out_res.r[k] = st_com_reg[QW-1].singular ? '0
                         : lane_result(st_lane_reg[QW-1][k], st_com_reg[QW-1].dmag);
        end
        out_res.det      = st_com_reg[QW-1].singular ? '0 : st_com_reg[QW-1].det_q;
        out_res.singular = st_com_reg[QW-1].singular;
    end

    assign out_valid = st_v_reg[QW-1];

endmodule

`default_nettype wire

>>> hdl/m3i_skid.sv
// Output register with a skid stage, so that the pipeline keeps taking words
// while one result waits. Depends on m3i_pkg.
`default_nettype none

module m3i_skid import m3i_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  res_t up_res,
    output logic up_ready,
    output logic down_valid,
    input  logic down_ready,
    output res_t down_res
);

    logic out_v_reg, out_v_next;
    logic skid_v_reg, skid_v_next;
    res_t out_res_reg, out_res_next;
    res_t skid_res_reg, skid_res_next;

    // Next state of the two slots.
    always_comb
    begin
        out_v_next    = out_v_reg;
        skid_v_next   = skid_v_reg;
        out_res_next  = out_res_reg;
        skid_res_next = skid_res_reg;
        if (skid_v_reg)
        begin
            if (down_ready)
            begin
                out_res_next = skid_res_reg;
                skid_v_next  = 1'b0;
            end
        end
        else if (!out_v_reg || down_ready)
        begin
            out_v_next   = up_valid;
            out_res_next = up_res;
        end
        else if (up_valid)
        begin
            skid_v_next   = 1'b1;
            skid_res_next = up_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign up_ready   = !skid_v_reg;
    assign down_valid = out_v_reg;
    assign down_res   = out_res_reg;

    // The skid slot is only used behind a waiting output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid slot full while output slot empty");

    // A word arriving at a stalled output is caught in the skid slot.
    a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !down_ready && !skid_v_reg && up_valid |=> skid_v_reg)
        else $error("word lost at stalled output");

    // A taken output word is replaced by the skid word.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg && down_ready |=> !skid_v_reg && out_v_reg)
        else $error("skid word not moved to output");

endmodule

`default_nettype wire
